@@ hw/rtl/hsvs_pkg.sv @@
package hsvs_pkg;

    localparam int NSTAGE = 5;

    localparam int HUE_W  = 16;
    localparam int CHAN_W = 8;

    localparam logic [CHAN_W-1:0] SAT_FULL = 8'd255;

    localparam int SEXT_COUNT = 6;

    // Reciprocal of six, scaled by 2**16 and rounded down.
    localparam logic [13:0] RECIP_SIX = 14'd10922;

    typedef enum logic [2:0] {
        SEXT_RED_YEL = 3'd0,
        SEXT_YEL_GRN = 3'd1,
        SEXT_GRN_CYN = 3'd2,
        SEXT_CYN_BLU = 3'd3,
        SEXT_BLU_MAG = 3'd4,
        SEXT_MAG_RED = 3'd5
    } sextant_t;

    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } pipe_ctl_t;

endpackage

@@ hw/rtl/hsvs_ctrl.sv @@
module hsvs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output hsvs_pkg::pipe_ctl_t ctl
);
    import hsvs_pkg::*;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] stage_ready;

    always_comb begin
        stage_ready[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb begin
        ctl.load[0]   = s_valid && stage_ready[0];
        valid_next[0] = stage_ready[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            ctl.load[k]   = valid_reg[k-1] && stage_ready[k];
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_ready[0];
    assign m_valid = valid_reg[NSTAGE-1];

`ifndef ASSERT_OFF
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("Accepted request did not reach the first stage.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("Stalled result was dropped.");

    a_load_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load[NSTAGE-1] |-> valid_reg[NSTAGE-2])
        else $error("Last stage loaded from an empty stage.");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[NSTAGE-2] && m_valid && m_ready |=> !m_valid)
        else $error("Result repeated after it was taken.");
`endif

endmodule

@@ hw/rtl/hsvs_hue.sv @@
module hsvs_hue #(
    parameter int unsigned HUE_PER_SEXTANT = 60,
    localparam int RW = (HUE_PER_SEXTANT > 1) ? $clog2(HUE_PER_SEXTANT) : 1
) (
    input  logic                             aclk,
    input  hsvs_pkg::pipe_ctl_t              ctl,
    input  logic [hsvs_pkg::HUE_W-1:0]       s_hue,
    output logic [RW-1:0]                    rem,
    output hsvs_pkg::sextant_t               sext
);
    import hsvs_pkg::*;

    localparam logic [16:0] RECIP_PER = 17'((32'd1 << 16) / HUE_PER_SEXTANT);
    localparam logic [HUE_W-1:0] PER = HUE_W'(HUE_PER_SEXTANT);

    logic [32:0]      hue_prod;
    logic [HUE_W-1:0] hue0_reg;
    logic [HUE_W-1:0] quot_est0_reg;

    logic [31:0]      back_prod;
    logic [HUE_W-1:0] rem_raw;
    logic             rem_over;
    logic [HUE_W-1:0] quot1_next;
    logic [RW-1:0]    rem1_next;
    logic [HUE_W-1:0] quot1_reg;
    logic [RW-1:0]    rem1_reg;

    logic [29:0]      six_prod;
    logic [13:0]      six_est2_reg;
    logic [HUE_W-1:0] quot2_reg;

    logic [HUE_W-1:0] six_back;
    logic [HUE_W-1:0] six_rem;
    logic [2:0]       sext3_next;
    sextant_t         sext3_reg;

    assign hue_prod = 33'(s_hue) * 33'(RECIP_PER);

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            hue0_reg      <= s_hue;
            quot_est0_reg <= hue_prod[31:16];
        end
    end

    always_comb begin
        back_prod  = 32'(quot_est0_reg) * 32'(PER);
        rem_raw    = hue0_reg - back_prod[HUE_W-1:0];
        rem_over   = rem_raw >= PER;
        quot1_next = quot_est0_reg + HUE_W'(rem_over);
        rem1_next  = rem_over ? RW'(rem_raw - PER) : RW'(rem_raw);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            quot1_reg <= quot1_next;
            rem1_reg  <= rem1_next;
        end
    end

    assign six_prod = 30'(quot1_reg) * 30'(RECIP_SIX);

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            quot2_reg    <= quot1_reg;
            six_est2_reg <= six_prod[29:16];
        end
    end

    always_comb begin
        six_back = HUE_W'(six_est2_reg) * HUE_W'(SEXT_COUNT);
        six_rem  = quot2_reg - six_back;
        sext3_next = (six_rem[3:0] >= 4'(SEXT_COUNT)) ?
                     3'(six_rem[3:0] - 4'(SEXT_COUNT)) : six_rem[2:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            sext3_reg <= sextant_t'(sext3_next);
        end
    end

    assign rem  = rem1_reg;
    assign sext = sext3_reg;

endmodule

@@ hw/rtl/hsvs_level.sv @@
module hsvs_level #(
    parameter int unsigned HUE_PER_SEXTANT = 60,
    localparam int RW = (HUE_PER_SEXTANT > 1) ? $clog2(HUE_PER_SEXTANT) : 1,
    localparam int DW = RW + 8
) (
    input  logic                         aclk,
    input  hsvs_pkg::pipe_ctl_t          ctl,
    input  logic [hsvs_pkg::CHAN_W-1:0]  s_saturation,
    input  logic [hsvs_pkg::CHAN_W-1:0]  s_brightness,
    input  logic [RW-1:0]                rem,
    output logic [hsvs_pkg::CHAN_W-1:0]  top,
    output logic [hsvs_pkg::CHAN_W-1:0]  bot,
    output logic [DW-1:0]                slope_prod,
    output logic [hsvs_pkg::CHAN_W-1:0]  adj_est
);
    import hsvs_pkg::*;

    localparam logic [DW:0] RECIP_PER = (DW+1)'((64'd1 << DW) / HUE_PER_SEXTANT);

    logic [15:0]       vs0_reg;
    logic [CHAN_W-1:0] top0_reg;

    logic [16:0]       scaled_sum;
    logic [CHAN_W-1:0] bot1_next;
    logic [CHAN_W-1:0] top1_reg;
    logic [CHAN_W-1:0] bot1_reg;

    logic [CHAN_W-1:0] span;
    logic [DW-1:0]     top2_reg;
    logic [DW-1:0]     dprod2_reg;
    logic [CHAN_W-1:0] bot2_reg;
    logic [CHAN_W-1:0] top2_val;

    logic [2*DW:0]     adj_prod;
    logic [CHAN_W-1:0] top3_reg;
    logic [CHAN_W-1:0] bot3_reg;
    logic [DW-1:0]     dprod3_reg;
    logic [CHAN_W-1:0] adj3_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            vs0_reg  <= 16'(s_brightness) * 16'(SAT_FULL - s_saturation);
            top0_reg <= s_brightness;
        end
    end

    // Exact floor division by 255 for any numerator up to 255 * 255.
    always_comb begin
        scaled_sum = 17'(vs0_reg) + 17'(vs0_reg[15:8]) + 17'd1;
        bot1_next  = scaled_sum[15:8];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            top1_reg <= top0_reg;
            bot1_reg <= bot1_next;
        end
    end

    assign span = top1_reg - bot1_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            top2_reg   <= DW'(top1_reg);
            bot2_reg   <= bot1_reg;
            dprod2_reg <= DW'(span) * DW'(rem);
        end
    end

    assign top2_val = top2_reg[CHAN_W-1:0];
    assign adj_prod = (2*DW+1)'(dprod2_reg) * (2*DW+1)'(RECIP_PER);

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            top3_reg   <= top2_val;
            bot3_reg   <= bot2_reg;
            dprod3_reg <= dprod2_reg;
            adj3_reg   <= adj_prod[DW+CHAN_W-1:DW];
        end
    end

    assign top        = top3_reg;
    assign bot        = bot3_reg;
    assign slope_prod = dprod3_reg;
    assign adj_est    = adj3_reg;

endmodule

@@ hw/rtl/hsvs_mix.sv @@
module hsvs_mix #(
    parameter int unsigned HUE_PER_SEXTANT = 60,
    localparam int RW = (HUE_PER_SEXTANT > 1) ? $clog2(HUE_PER_SEXTANT) : 1,
    localparam int DW = RW + 8
) (
    input  logic                         aclk,
    input  hsvs_pkg::pipe_ctl_t          ctl,
    input  hsvs_pkg::sextant_t           sext,
    input  logic [hsvs_pkg::CHAN_W-1:0]  top,
    input  logic [hsvs_pkg::CHAN_W-1:0]  bot,
    input  logic [DW-1:0]                slope_prod,
    input  logic [hsvs_pkg::CHAN_W-1:0]  adj_est,
    output logic [hsvs_pkg::CHAN_W-1:0]  m_red,
    output logic [hsvs_pkg::CHAN_W-1:0]  m_green,
    output logic [hsvs_pkg::CHAN_W-1:0]  m_blue
);
    import hsvs_pkg::*;

    localparam logic [DW-1:0] PER = DW'(HUE_PER_SEXTANT);

    logic [DW-1:0]     back_prod;
    logic [DW-1:0]     slope_rem;
    logic [CHAN_W-1:0] adj;
    logic [CHAN_W-1:0] rise;
    logic [CHAN_W-1:0] fall;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;

    always_comb begin
        back_prod = DW'(adj_est) * PER;
        slope_rem = slope_prod - back_prod;
        adj       = adj_est + CHAN_W'(slope_rem >= PER);
        rise      = bot + adj;
        fall      = top - adj;
        unique case (sext)
            SEXT_RED_YEL: begin
                red_next = top;  green_next = rise; blue_next = bot;
            end
            SEXT_YEL_GRN: begin
                red_next = fall; green_next = top;  blue_next = bot;
            end
            SEXT_GRN_CYN: begin
                red_next = bot;  green_next = top;  blue_next = rise;
            end
            SEXT_CYN_BLU: begin
                red_next = bot;  green_next = fall; blue_next = top;
            end
            SEXT_BLU_MAG: begin
                red_next = rise; green_next = bot;  blue_next = top;
            end
            default: begin
                red_next = top;  green_next = bot;  blue_next = fall;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[NSTAGE-1]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

endmodule

@@ hw/rtl/hsv_to_rgb_sextant.sv @@
// Converts one pixel per clock, while the output side does not stall, from hue,
// saturation and value to 8-bit red, green and blue. The hue wraps modulo six sextants
// of HUE_PER_SEXTANT steps each (0 to 359 with the default of 60). Each request goes
// through a five-stage pipeline. A new request is accepted in every cycle while the
// output side does not stall. Each stage carries its own valid bit and holds its item
// while the stage after it cannot take it, so bubbles close up. While a finished result
// waits to be taken, requests are still accepted until all five stages hold an item.
module hsv_to_rgb_sextant #(
    parameter int unsigned HUE_PER_SEXTANT = 60
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hsvs_pkg::HUE_W-1:0]  s_hue,
    input  logic [hsvs_pkg::CHAN_W-1:0] s_saturation,
    input  logic [hsvs_pkg::CHAN_W-1:0] s_brightness,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hsvs_pkg::CHAN_W-1:0] m_red,
    output logic [hsvs_pkg::CHAN_W-1:0] m_green,
    output logic [hsvs_pkg::CHAN_W-1:0] m_blue
);
    import hsvs_pkg::*;

    localparam int RW = (HUE_PER_SEXTANT > 1) ? $clog2(HUE_PER_SEXTANT) : 1;
    localparam int DW = RW + 8;

    pipe_ctl_t         ctl;
    logic [RW-1:0]     rem;
    sextant_t          sext;
    logic [CHAN_W-1:0] top;
    logic [CHAN_W-1:0] bot;
    logic [DW-1:0]     slope_prod;
    logic [CHAN_W-1:0] adj_est;

    hsvs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    hsvs_hue #(
        .HUE_PER_SEXTANT (HUE_PER_SEXTANT)
    ) u_hue (
        .aclk  (aclk),
        .ctl   (ctl),
        .s_hue (s_hue),
        .rem   (rem),
        .sext  (sext)
    );

    hsvs_level #(
        .HUE_PER_SEXTANT (HUE_PER_SEXTANT)
    ) u_level (
        .aclk         (aclk),
        .ctl          (ctl),
        .s_saturation (s_saturation),
        .s_brightness (s_brightness),
        .rem          (rem),
        .top          (top),
        .bot          (bot),
        .slope_prod   (slope_prod),
        .adj_est      (adj_est)
    );

    hsvs_mix #(
        .HUE_PER_SEXTANT (HUE_PER_SEXTANT)
    ) u_mix (
        .aclk       (aclk),
        .ctl        (ctl),
        .sext       (sext),
        .top        (top),
        .bot        (bot),
        .slope_prod (slope_prod),
        .adj_est    (adj_est),
        .m_red      (m_red),
        .m_green    (m_green),
        .m_blue     (m_blue)
    );

endmodule
